[sv/gcf_pkg.sv]
// gcf_pkg: shared types and constants for the gradient contour filter.
// No dependencies; used by every module of the block.
`default_nettype none

package gcf_pkg;

  // default build parameters
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_PIXEL_BITS = 8;

  // frame geometry
  localparam int MAX_HEIGHT = 2048;
  localparam int POS_W      = 11;   // row / column result fields

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

  // queue between front and back
  localparam int FIFO_DEPTH = 4;

  // what one queued pixel asks the back end to emit
  typedef struct packed {
    logic             emit_prev;  // gradient result for the row above
    logic             emit_self;  // pass-through result on the last row
    logic             frame_end;  // last pixel of the frame
    logic [POS_W-1:0] row;        // row of the input pixel
    logic [POS_W-1:0] col;        // column of the input pixel
  } gcf_ctrl_t;

endpackage

`default_nettype wire

[sv/gcf_front.sv]
// gcf_front: config registers, raster counters, line store and gradient math.
// Depends on gcf_pkg. Feeds classified pixels to the queue.
`default_nettype none

module gcf_front #(
  parameter int MAX_WIDTH  = gcf_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gcf_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // pixel input
  input  wire logic [PIXEL_BITS-1:0]          pixel_in,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  // config write
  input  wire logic                           cfg_wr,
  input  wire logic [gcf_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [gcf_pkg::CFG_DATA_W-1:0] cfg_data,
  // queue push side
  output logic                                q_valid,
  input  wire logic                           q_ready,
  output gcf_pkg::gcf_ctrl_t                  q_ctrl,
  output logic [PIXEL_BITS:0]                 q_grad,
  output logic [PIXEL_BITS-1:0]               q_pix
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = gcf_pkg::POS_W;

  // clamped dimensions, stored as size minus one
  logic [CW-1:0] width_m1;
  logic [PW-1:0] height_m1;

  logic [CW-1:0] col;
  logic [PW-1:0] row;

  logic          last_col;
  logic          last_row;
  logic          accept;

  // line store: previous row
  logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_here;
  logic [PIXEL_BITS-1:0] rd_right;

  // stage 1 registers
  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [CW-1:0]         s1_col;
  logic [PW-1:0]         s1_row;
  logic                  s1_emit_prev;
  logic                  s1_emit_self;
  logic                  s1_frame_end;
  logic                  s1_last_col;
  logic                  s1_live;

  logic [PIXEL_BITS-1:0] diff_down;
  logic [PIXEL_BITS-1:0] diff_right;

  assign last_col = (col == width_m1);
  assign last_row = (row == height_m1);

  // s1 holds only when it has something to push and the queue is full
  assign s1_live  = s1_valid && (s1_emit_prev || s1_emit_self);
  assign in_stall = s1_live && !q_ready;
  assign accept   = in_valid && !in_stall;

  // config registers, zero counts as one, oversize saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= CW'(MAX_WIDTH - 1);
      height_m1 <= PW'(gcf_pkg::MAX_HEIGHT - 1);
    end else if (cfg_wr) begin
      if (cfg_index == gcf_pkg::REG_IMAGE_WIDTH) begin
        if (cfg_data == '0) begin
          width_m1 <= '0;
        end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
          width_m1 <= CW'(MAX_WIDTH - 1);
        end else begin
          width_m1 <= CW'(cfg_data - gcf_pkg::CFG_DATA_W'(1));
        end
      end else if (cfg_index == gcf_pkg::REG_IMAGE_HEIGHT) begin
        if (cfg_data == '0) begin
          height_m1 <= '0;
        end else if (32'(cfg_data) > 32'(gcf_pkg::MAX_HEIGHT)) begin
          height_m1 <= PW'(gcf_pkg::MAX_HEIGHT - 1);
        end else begin
          height_m1 <= PW'(cfg_data - gcf_pkg::CFG_DATA_W'(1));
        end
      end
    end
  end

  // raster counters; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_wr && (cfg_index == gcf_pkg::REG_IMAGE_WIDTH ||
                            cfg_index == gcf_pkg::REG_IMAGE_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + PW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // line store: read old row at c and c+1, overwrite c with the new pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_here      <= line_mem[col];
      rd_right     <= line_mem[CW'(col + CW'(1))];
      line_mem[col] <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix       <= pixel_in;
      s1_col       <= col;
      s1_row       <= row;
      s1_emit_prev <= (row != '0);
      s1_emit_self <= last_row;
      s1_frame_end <= last_row && last_col;
      s1_last_col  <= last_col;
    end
  end

  // |below - here| + |right - here|, or here on the last column
  assign diff_down  = (s1_pix > rd_here) ? s1_pix - rd_here : rd_here - s1_pix;
  assign diff_right = (rd_right > rd_here) ? rd_right - rd_here : rd_here - rd_right;

  always_comb begin
    q_valid          = s1_live;
    q_ctrl.emit_prev = s1_emit_prev;
    q_ctrl.emit_self = s1_emit_self;
    q_ctrl.frame_end = s1_frame_end;
    q_ctrl.row       = s1_row;
    q_ctrl.col       = PW'(s1_col);
    q_pix            = s1_pix;
    if (s1_last_col) begin
      q_grad = {1'b0, rd_here};
    end else begin
      q_grad = {1'b0, diff_down} + {1'b0, diff_right};
    end
  end

endmodule

`default_nettype wire

[sv/gcf_fifo.sv]
// gcf_fifo: small register queue between front and back ends.
// Depends on gcf_pkg for its depth.
`default_nettype none

module gcf_fifo #(
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   wr_ready,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   rd_valid
);

  localparam int DEPTH = gcf_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              do_push;
  logic              do_pop;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_push  = push && wr_ready;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/gcf_back.sv]
// gcf_back: expands queued pixels into one or two results, output register.
// Depends on gcf_pkg.
`default_nettype none

module gcf_back #(
  parameter int PIXEL_BITS = gcf_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // queue pop side
  input  wire logic                        head_valid,
  input  wire gcf_pkg::gcf_ctrl_t          head_ctrl,
  input  wire logic [PIXEL_BITS:0]         head_grad,
  input  wire logic [PIXEL_BITS-1:0]       head_pix,
  output logic                             head_pop,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [PIXEL_BITS:0]              edge_value,
  output logic [gcf_pkg::POS_W-1:0]        out_row,
  output logic [gcf_pkg::POS_W-1:0]        out_col,
  output logic                             frame_last
);

  localparam int PW = gcf_pkg::POS_W;

  logic phase;      // 1: gradient result already sent, pass-through next
  logic load;
  logic fire;
  logic send_prev;

  assign load      = !out_valid || !out_stall;
  assign fire      = head_valid && load;
  assign send_prev = head_ctrl.emit_prev && !phase;
  assign head_pop  = fire && !(send_prev && head_ctrl.emit_self);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= fire;
      end
      if (fire) begin
        phase <= send_prev && head_ctrl.emit_self;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_col <= head_ctrl.col;
      if (send_prev) begin
        edge_value <= head_grad;
        out_row    <= head_ctrl.row - PW'(1);
        frame_last <= 1'b0;
      end else begin
        edge_value <= {1'b0, head_pix};
        out_row    <= head_ctrl.row;
        frame_last <= head_ctrl.frame_end;
      end
    end
  end

endmodule

`default_nettype wire

[sv/gradient_contour_filter.sv]
// gradient_contour_filter: top level of the L1 forward-difference gradient filter.
// Depends on gcf_pkg, gcf_front, gcf_fifo and gcf_back.
//
// Use:
//   Pixels enter in raster order on pixel_in with in_valid / in_stall; a
//   transfer happens on a clock edge with in_valid high and in_stall low.
//   Results leave on edge_value, out_row, out_col, frame_last with
//   out_valid / out_stall, same transfer rule.
//   image_width (index 0) and image_height (index 1) are written through
//   cfg_valid / cfg_ready / cfg_index / cfg_data while the block is idle;
//   any write to either register restarts the frame at row 0, column 0.
//   Result (r-1,c) is formed from pixel (r,c) and the stored row. On the last row each
//   pixel also yields its own pass-through result, sent right after.
//   A result leaves through the line store read stage, the queue and the
//   output register after the pixel that completes it.
//   Throughput: one pixel per cycle on all rows but the last while no stall
//   holds the flow; on the last row the single result port sets the pace.
//   The first row produces nothing unless the image is one row high.
//   A four-entry queue parts front and back; a stalled receiver fills it,
//   then in_stall rises. No pixel or result is dropped.
//   Reset: counters and queue clear, width and height go to their maximum.
//   The line store needs no clearing.
`default_nettype none

module gradient_contour_filter #(
  parameter int MAX_WIDTH  = gcf_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gcf_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // pixel channel
  input  wire logic [PIXEL_BITS-1:0]          pixel_in,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  // result channel
  output logic [PIXEL_BITS:0]                 edge_value,
  output logic [gcf_pkg::POS_W-1:0]           out_row,
  output logic [gcf_pkg::POS_W-1:0]           out_col,
  output logic                                frame_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gcf_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [gcf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CTRL_W = $bits(gcf_pkg::gcf_ctrl_t);
  localparam int Q_W    = CTRL_W + (PIXEL_BITS + 1) + PIXEL_BITS;

  // front -> queue
  logic                  q_valid;
  logic                  q_ready;
  gcf_pkg::gcf_ctrl_t    q_ctrl;
  logic [PIXEL_BITS:0]   q_grad;
  logic [PIXEL_BITS-1:0] q_pix;

  // queue -> back
  logic [Q_W-1:0]        head_data;
  logic                  head_valid;
  logic                  head_pop;
  gcf_pkg::gcf_ctrl_t    head_ctrl;
  logic [PIXEL_BITS:0]   head_grad;
  logic [PIXEL_BITS-1:0] head_pix;

  // registers always writable; user must keep writes to idle; not enforced
  assign cfg_ready = 1'b1;

  gcf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_ctrl    (q_ctrl),
    .q_grad    (q_grad),
    .q_pix     (q_pix)
  );

  gcf_fifo #(
    .DATA_W (Q_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_valid),
    .wr_data  ({q_ctrl, q_grad, q_pix}),
    .wr_ready (q_ready),
    .pop      (head_pop),
    .rd_data  (head_data),
    .rd_valid (head_valid)
  );

  assign {head_ctrl, head_grad, head_pix} = head_data;

  gcf_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ctrl  (head_ctrl),
    .head_grad  (head_grad),
    .head_pix   (head_pix),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_value (edge_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

endmodule

`default_nettype wire
